@@ rtl/crsg_pkg.sv @@
`default_nettype none

package crsg_pkg;

	localparam int RADIUS_W   = 10;
	localparam int RADIUS_MAX = 1007;
	localparam int XOUT_W     = 6;
	localparam int YOUT_W     = 6;
	localparam int XOUT_MAX   = (1 << XOUT_W) - 1;
	// squared terms: (2*1007-1)^2 and 4*1007^2 both fit in 22 bits
	localparam int SQ_W       = 22;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQUARE,
		ST_STEP,
		ST_FLUSH
	} crsg_state_t;

	typedef struct packed {
		logic load_radius;
		logic init;
		logic square;
		logic step_col;
		logic advance_row;
		logic emit;
		logic emit_last;
		logic capture;
	} crsg_cmd_t;

	typedef struct packed {
		logic col_step;
		logic term;
		logic at_limit;
		logic out_free;
	} crsg_status_t;

	function automatic logic [XOUT_W-1:0] sat_x(input logic [RADIUS_W-1:0] x);
		logic [XOUT_W-1:0] r;
		if (x > RADIUS_W'(XOUT_MAX)) begin
			r = XOUT_W'(XOUT_MAX);
		end else begin
			r = x[XOUT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/crsg_ctrl.sv @@
`default_nettype none

module crsg_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire crsg_pkg::crsg_status_t st,
	output crsg_pkg::crsg_cmd_t        cmd
);
	import crsg_pkg::*;

	crsg_state_t state_q;
	crsg_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_LOAD;
			end
			ST_LOAD:   state_nxt = ST_SQUARE;
			ST_SQUARE: state_nxt = ST_STEP;
			ST_STEP: begin
				if (!st.col_step && st.out_free) begin
					priority if (st.term)     state_nxt = ST_IDLE;
					else if (st.at_limit)     state_nxt = ST_FLUSH;
					else                      state_nxt = ST_STEP;
				end
			end
			ST_FLUSH: begin
				if (st.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.load_radius = in_valid;
			end
			ST_LOAD:   cmd.init = 1'b1;
			ST_SQUARE: cmd.square = 1'b1;
			ST_STEP: begin
				if (st.col_step) begin
					cmd.step_col = 1'b1;
				end else if (st.out_free) begin
					// finished row: ship the held row, keep the new one if the run goes on
					cmd.emit        = 1'b1;
					cmd.emit_last   = st.term;
					cmd.capture     = !st.term;
					cmd.advance_row = !st.term && !st.at_limit;
				end
			end
			ST_FLUSH: begin
				cmd.emit      = st.out_free;
				cmd.emit_last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/crsg_dpath.sv @@
`default_nettype none

module crsg_dpath #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [crsg_pkg::RADIUS_W-1:0]     radius_in,
	input  wire crsg_pkg::crsg_cmd_t               cmd,
	output crsg_pkg::crsg_status_t                 st,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [crsg_pkg::XOUT_W-1:0]            x_out,
	output logic [crsg_pkg::YOUT_W-1:0]            y_out,
	output logic                                   last_out
);
	import crsg_pkg::*;

	localparam int YW   = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
	localparam int DYW  = $clog2(2 * MAX_ROWS);
	localparam int DY2W = 2 * DYW;
	localparam int XW   = RADIUS_W;
	localparam int DXW  = RADIUS_W + 1;
	localparam int SW   = SQ_W + 1;
	localparam int TW   = (DYW + FRAC_BITS > RADIUS_W + 1) ?
	                      DYW + FRAC_BITS + 1 : RADIUS_W + 2;
	localparam int HALF = (1 << FRAC_BITS) >> 1;

	logic [RADIUS_W-1:0] r_q;
	logic [SQ_W-1:0]     a_q;     // 4*r^2 >> 2*FRAC_BITS
	logic [XW-1:0]       x_q;
	logic [DXW-1:0]      dx_q;
	logic [SQ_W-1:0]     dx2_q;
	logic [YW-1:0]       y_q;
	logic [DYW-1:0]      dy_q;
	logic [DY2W-1:0]     dy2_q;
	logic [XOUT_W-1:0]   px_q;
	logic [YW-1:0]       py_q;
	logic                out_valid_q;
	logic [XOUT_W-1:0]   xo_q;
	logic [YOUT_W-1:0]   yo_q;
	logic                lo_q;

	logic [RADIUS_W:0]   r_half;
	logic [XW-1:0]       x_init;
	logic [2*RADIUS_W-1:0] r_sq;
	logic [SQ_W-1:0]     four_r2;
	logic [SW-1:0]       s_sum;

	always_comb begin
		r_half  = {1'b0, r_q} + (RADIUS_W + 1)'(HALF);
		x_init  = XW'(r_half >> FRAC_BITS);
		r_sq    = r_q * r_q;
		four_r2 = {r_sq, 2'b00};
		s_sum   = SW'(dx2_q) + SW'(dy2_q);
	end

	always_comb begin
		st.col_step = (x_q != '0) && (SW'(a_q) < s_sum);
		st.term     = (x_q == '0) &&
		              ((TW'(r_q) << 1) < (TW'(dy_q) << FRAC_BITS));
		st.at_limit = (y_q == YW'(MAX_ROWS - 1));
		st.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_radius) begin
			r_q <= (radius_in > RADIUS_W'(RADIUS_MAX)) ? RADIUS_W'(RADIUS_MAX) : radius_in;
		end
		if (cmd.init) begin
			a_q   <= four_r2 >> (2 * FRAC_BITS);
			x_q   <= x_init;
			dx_q  <= {x_init, 1'b0} - DXW'(1);
			y_q   <= YW'(1);
			dy_q  <= DYW'(1);
			dy2_q <= DY2W'(1);
			px_q  <= sat_x(x_init);
			py_q  <= '0;
		end
		if (cmd.square) begin
			dx2_q <= dx_q * dx_q;
		end
		if (cmd.step_col) begin
			x_q   <= x_q - XW'(1);
			dx_q  <= dx_q - DXW'(2);
			dx2_q <= dx2_q - (SQ_W'(dx_q) << 2) + SQ_W'(4);
		end
		if (cmd.advance_row) begin
			y_q   <= y_q + YW'(1);
			dy_q  <= dy_q + DYW'(2);
			dy2_q <= dy2_q + (DY2W'(dy_q) << 2) + DY2W'(4);
		end
		if (cmd.emit) begin
			xo_q <= px_q;
			yo_q <= YOUT_W'(py_q);
			lo_q <= cmd.emit_last;
		end
		if (cmd.capture) begin
			px_q <= sat_x(x_q);
			py_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign x_out     = xo_q;
	assign y_out     = yo_q;
	assign last_out  = lo_q;

endmodule

`default_nettype wire

@@ rtl/circle_row_span_generator.sv @@
// Circle row span generator.
// Input channel (in_valid/in_ready): one beat carries radius_cells_q4, a radius
// in cells with FRAC_BITS fractional bits; values above 1007 saturate.
// Output channel (out_valid/out_ready): one beat per row, starting at row 0,
// with the half width of the footprint (x_half_width), the row distance
// (row_offset) and last_row set on the final row. At most MAX_ROWS rows.
// Sequence: setup (radius load, 4*R^2 and initial column, column square), then
// the sequencer steps the column down while it lies outside the circle and emits
// a row at each finished row, holding while the result register is full; at the
// row limit the last row goes out from a flush state.
// One circle runs at a time: in_ready is high only while no circle is active.
// The result register lets the generator run ahead by one row; while the
// receiver stalls with a row held, the sequencer waits at the next finished row.
// Reset clears the sequencer and the output valid; a circle in flight is lost.
`default_nettype none

module circle_row_span_generator #(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [crsg_pkg::RADIUS_W-1:0]  radius_cells_q4,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [crsg_pkg::XOUT_W-1:0]         x_half_width,
	output logic [crsg_pkg::YOUT_W-1:0]         row_offset,
	output logic                                last_row
);
	import crsg_pkg::*;

	crsg_cmd_t    cmd;
	crsg_status_t st;

	crsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	crsg_dpath #(
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.radius_in (radius_cells_q4),
		.cmd       (cmd),
		.st        (st),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.x_out     (x_half_width),
		.y_out     (row_offset),
		.last_out  (last_row)
	);

`ifndef NO_ASSERTIONS
	// a taken radius starts a run, so no second beat right behind it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// while a non-final row is waiting, the circle is still running
	a_busy_mid_circle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_row |-> !in_ready)
		else $error("idle with a non-final row pending");
`endif

endmodule

`default_nettype wire

@@ sim/tb_circle_row_span_generator.sv @@
`default_nettype none

module tb_circle_row_span_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import crsg_pkg::*;

	localparam int MAX_ROWS    = 64;
	localparam int FRAC_BITS   = 4;
	localparam int HALF_CELL   = (1 << FRAC_BITS) >> 1;
	localparam int CYCLE_LIMIT = 500000;
	// idle tail after the last row is drained, as a margin
	localparam int TAIL_CYCLES = 300;

	typedef struct packed {
		logic [XOUT_W-1:0] x_half_width;
		logic [YOUT_W-1:0] row_offset;
		logic              last_row;
	} span_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	logic [RADIUS_W-1:0] radius_cells_q4 = '0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic [XOUT_W-1:0]   x_half_width;
	logic [YOUT_W-1:0]   row_offset;
	logic                last_row;

	span_t       span_q[$];
	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	bit          send_idle   = 1'b1;
	bit          recv_idle   = 1'b1;

	circle_row_span_generator #(
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.radius_cells_q4 (radius_cells_q4),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.x_half_width    (x_half_width),
		.row_offset      (row_offset),
		.last_row        (last_row)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("circle_row_span_generator test failed");
			$finish;
		end
	end

	function automatic span_t make_span(input int unsigned x, input int unsigned y);
		span_t s;
		s.x_half_width = (x > XOUT_MAX) ? XOUT_W'(XOUT_MAX) : XOUT_W'(x);
		s.row_offset   = YOUT_W'(y);
		s.last_row     = 1'b0;
		return s;
	endfunction

	// queue every row span of one circle, centre row first
	function automatic void predict_spans(input logic [RADIUS_W-1:0] raw);
		longint unsigned r;
		longint unsigned four_r2;
		longint unsigned dy;
		longint unsigned dx;
		longint unsigned dist2;
		int unsigned     x;
		int unsigned     y;
		int              rows;
		r       = (raw > RADIUS_MAX) ? RADIUS_MAX : raw;
		four_r2 = 4 * r * r;
		x       = int'((r + HALF_CELL) >> FRAC_BITS);
		y       = 0;
		span_q.insert(span_q.size(), make_span(x, y));
		rows = 1;
		while (rows < MAX_ROWS) begin
			y++;
			dy = 2 * y - 1;
			// pull the column in until the inner corner is inside
			while (x > 0) begin
				dx    = 2 * x - 1;
				dist2 = (dy * dy + dx * dx) << (2 * FRAC_BITS);
				if (!(four_r2 < dist2))
					break;
				x--;
			end
			if (x == 0 && 2 * r < (dy << FRAC_BITS))
				break;
			span_q.insert(span_q.size(), make_span(x, y));
			rows++;
		end
		span_q[span_q.size() - 1].last_row = 1'b1;
	endfunction

	task automatic send_radius(input logic [RADIUS_W-1:0] radius);
		int gap;
		gap = send_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		radius_cells_q4 <= radius;
		do @(posedge clk); while (!in_ready);
		predict_spans(radius);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (span_q.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls between beats
	initial begin
		int gap;
		forever begin
			gap = recv_idle ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		span_t want;
		if (arst_n && out_valid && out_ready) begin
			if (span_q.size() == 0) begin
				$error("unexpected beat: x=%0d y=%0d last=%0b",
					x_half_width, row_offset, last_row);
				error_count++;
			end else begin
				want = span_q.pop_front();
				if (x_half_width !== want.x_half_width) begin
					$error("x_half_width: expected %0d, got %0d",
						want.x_half_width, x_half_width);
					error_count++;
				end
				if (row_offset !== want.row_offset) begin
					$error("row_offset: expected %0d, got %0d",
						want.row_offset, row_offset);
					error_count++;
				end
				if (last_row !== want.last_row) begin
					$error("last_row: expected %0b, got %0b",
						want.last_row, last_row);
					error_count++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_radius(10'd0);
		send_radius(10'd1);
		send_radius(10'd1007);
		send_radius(10'd1000);
		send_radius(10'd1006);
		send_radius(10'd512);
		send_radius(10'd341);
	endtask

	// round(R) half up: values at and next to half-cell points and cell boundaries
	task automatic test_rounding();
		send_radius(10'd7);
		send_radius(10'd8);
		send_radius(10'd9);
		send_radius(10'd16);
		send_radius(10'd23);
		send_radius(10'd24);
		send_radius(10'd40);
		send_radius(10'd1000 - 10'd8);
		send_radius(10'd15);
	endtask

	task automatic test_saturation();
		send_radius(10'd1008);
		send_radius(10'd1023);
		send_radius(10'h2AA);
		send_radius(10'h155);
	endtask

	task automatic test_drain_pause();
		send_radius(10'd200);
		wait_drained();
		send_radius(10'd0);
		wait_drained();
		send_radius(10'd999);
	endtask

	task automatic test_random(input int count);
		int                  pick;
		logic [RADIUS_W-1:0] radius;
		for (int i = 0; i < count; i++) begin
			// swap idling patterns every quarter
			send_idle = ((i / (count / 4)) % 2) == 0;
			recv_idle = ((i / (count / 4)) < 2) ? send_idle : !send_idle;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				radius = RADIUS_W'($urandom_range(0, 1023));
			else if (pick < 8)
				radius = RADIUS_W'($urandom_range(0, 160));
			else if (pick < 9)
				radius = RADIUS_W'($urandom_range(990, 1023));
			else
				radius = RADIUS_W'($urandom_range(0, 62) * 16 + HALF_CELL);
			send_radius(radius);
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_rounding();
		test_saturation();
		test_drain_pause();
		test_random(87);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && span_q.size() == 0) begin
			$display("circle_row_span_generator test passed");
		end else begin
			$display("circle_row_span_generator test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
